@@ hw/rtl/tccw_pkg.sv @@
// Shared constants, types and helpers of the text console character writer.
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_SPACES = 5;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);
    localparam int POS_W  = 11;
    localparam int BYTE_W = 8;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [TAB_W-1:0]  t_tab;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_byte CH_CR      = 8'd13;
    localparam t_byte CH_LF      = 8'd10;
    localparam t_byte CH_TAB     = 8'd9;
    localparam t_byte BLANK_CHAR = 8'h20;
    localparam t_byte BLANK_ATTR = 8'h07;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SETALL = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD_WAIT,
        S_TAB,
        S_SCR_COPY,
        S_SCR_FILL,
        S_CLEAR,
        S_SETALL,
        S_FINISH
    } t_state;

    function automatic t_addr cell_addr(input t_row row, input t_col col);
        return t_addr'(int'(row) * COLUMNS + int'(col));
    endfunction

    function automatic t_pos cursor_pos(input t_row row, input t_col col);
        return t_pos'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

@@ hw/rtl/tccw_if.sv @@
// Valid/ready channel interfaces for console operations and results.
interface tccw_in_if;
    logic            valid;
    logic            ready;
    tccw_pkg::t_op   operation;
    tccw_pkg::t_byte ch;
    tccw_pkg::t_byte color;
    logic [10:0]     cell_index;

    modport source (output valid, output operation, output ch, output color,
                    output cell_index, input ready);
    modport sink   (input valid, input operation, input ch, input color,
                    input cell_index, output ready);
endinterface

interface tccw_out_if;
    logic            valid;
    logic            ready;
    tccw_pkg::t_pos  cursor_position;
    tccw_pkg::t_byte cell_char;
    tccw_pkg::t_byte cell_color;

    modport source (output valid, output cursor_position, output cell_char,
                    output cell_color, input ready);
    modport sink   (input valid, input cursor_position, input cell_char,
                    input cell_color, output ready);
endinterface

@@ hw/rtl/text_console_char_writer.sv @@
// Text console: character/attribute memories, cursor and operation sequencer.
//
//  channel | dir | beat contents
//  i_in    | in  | operation, ch, color, cell_index
//  o_out   | out | cursor_position, cell_char, cell_color
//
// Return, line feed and plain characters are handled in their accept cycle; a
// read goes through the registered memory read and S_RD_WAIT; a tab writes
// TAB_SPACES blank cells. A scroll copies the rows up and blanks the last row.
// Clear and set-all make one memory port pass per cell. After reset a clearing
// pass over all CELLS (2000) cells fills the memories with i_in.ready low.
// A result stalled on o_out holds i_in.ready low until it is taken.
module text_console_char_writer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tccw_in_if.sink         i_in,
    tccw_out_if.source      o_out
);

    tccw_pkg::t_byte r_char_mem [tccw_pkg::CELLS];
    tccw_pkg::t_byte r_attr_mem [tccw_pkg::CELLS];
    tccw_pkg::t_byte r_rd_char;
    tccw_pkg::t_byte r_rd_attr;

    tccw_pkg::t_state r_state, n_state;
    tccw_pkg::t_addr  r_cnt, n_cnt;
    tccw_pkg::t_col   r_col, n_col;
    tccw_pkg::t_row   r_row, n_row;
    tccw_pkg::t_tab   r_tab, n_tab;
    tccw_pkg::t_byte  r_color, n_color;
    logic             r_hit, n_hit;

    logic             r_out_valid;
    tccw_pkg::t_pos   r_out_pos;
    tccw_pkg::t_byte  r_out_char;
    tccw_pkg::t_byte  r_out_color;

    logic             char_we, attr_we, rd_en, out_load, out_free, in_fire;
    tccw_pkg::t_addr  wa, rd_addr, cur_addr;
    tccw_pkg::t_byte  char_wd, attr_wd, out_char, out_color;
    tccw_pkg::t_pos   out_pos;
    logic             wrap, last_row;
    tccw_pkg::t_col   step_col;
    tccw_pkg::t_row   step_row;

    assign out_free = !r_out_valid || o_out.ready;
    assign in_fire  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == tccw_pkg::S_IDLE) && out_free;

    // one cell write and cursor advance
    assign cur_addr = tccw_pkg::cell_addr(r_row, r_col);
    assign wrap     = (r_col == tccw_pkg::t_col'(tccw_pkg::COLUMNS - 1));
    assign last_row = (r_row == tccw_pkg::t_row'(tccw_pkg::ROWS - 1));
    assign step_col = wrap ? '0 : r_col + tccw_pkg::t_col'(1);
    assign step_row = (wrap && !last_row) ? r_row + tccw_pkg::t_row'(1) : r_row;

    assign out_pos = tccw_pkg::cursor_pos(n_row, n_col);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_col     = r_col;
        n_row     = r_row;
        n_tab     = r_tab;
        n_color   = r_color;
        n_hit     = r_hit;
        char_we   = 1'b0;
        attr_we   = 1'b0;
        wa        = cur_addr;
        char_wd   = tccw_pkg::BLANK_CHAR;
        attr_wd   = tccw_pkg::BLANK_ATTR;
        rd_en     = 1'b0;
        rd_addr   = r_cnt;
        out_load  = 1'b0;
        out_char  = '0;
        out_color = '0;

        case (r_state)
            tccw_pkg::S_INIT: begin
                char_we = 1'b1;
                attr_we = 1'b1;
                wa      = r_cnt;
                if (r_cnt == tccw_pkg::t_addr'(tccw_pkg::CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = tccw_pkg::S_IDLE;
                end else begin
                    n_cnt = r_cnt + tccw_pkg::t_addr'(1);
                end
            end

            tccw_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (i_in.operation)
                        tccw_pkg::OP_PUT: begin
                            n_tab = '0;
                            if (i_in.ch == tccw_pkg::CH_CR) begin
                                n_col    = '0;
                                out_load = 1'b1;
                            end else if (i_in.ch == tccw_pkg::CH_LF) begin
                                n_col = '0;
                                if (last_row) begin
                                    n_cnt   = '0;
                                    n_state = tccw_pkg::S_SCR_COPY;
                                end else begin
                                    n_row    = r_row + tccw_pkg::t_row'(1);
                                    out_load = 1'b1;
                                end
                            end else begin
                                char_we = 1'b1;
                                attr_we = 1'b1;
                                char_wd = (i_in.ch == tccw_pkg::CH_TAB) ?
                                          tccw_pkg::BLANK_CHAR : i_in.ch;
                                attr_wd = i_in.color;
                                n_color = i_in.color;
                                n_col   = step_col;
                                n_row   = step_row;
                                if (i_in.ch == tccw_pkg::CH_TAB)
                                    n_tab = tccw_pkg::t_tab'(tccw_pkg::TAB_SPACES - 1);
                                if (wrap && last_row) begin
                                    n_cnt   = '0;
                                    n_state = tccw_pkg::S_SCR_COPY;
                                end else if (i_in.ch == tccw_pkg::CH_TAB &&
                                             tccw_pkg::TAB_SPACES > 1) begin
                                    n_state = tccw_pkg::S_TAB;
                                end else begin
                                    out_load = 1'b1;
                                end
                            end
                        end
                        tccw_pkg::OP_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_cnt   = '0;
                            n_state = tccw_pkg::S_CLEAR;
                        end
                        tccw_pkg::OP_SETALL: begin
                            n_color = i_in.color;
                            n_cnt   = '0;
                            n_state = tccw_pkg::S_SETALL;
                        end
                        tccw_pkg::OP_READ: begin
                            n_hit   = int'(i_in.cell_index) < tccw_pkg::CELLS;
                            rd_en   = n_hit;
                            rd_addr = tccw_pkg::t_addr'(i_in.cell_index);
                            n_state = tccw_pkg::S_RD_WAIT;
                        end
                        default: n_state = tccw_pkg::S_IDLE;
                    endcase
                end
            end

            tccw_pkg::S_RD_WAIT: begin
                out_load  = 1'b1;
                out_char  = r_hit ? r_rd_char : '0;
                out_color = r_hit ? r_rd_attr : '0;
                n_state   = tccw_pkg::S_IDLE;
            end

            tccw_pkg::S_TAB: begin
                char_we = 1'b1;
                attr_we = 1'b1;
                attr_wd = r_color;
                n_col   = step_col;
                n_row   = step_row;
                n_tab   = r_tab - tccw_pkg::t_tab'(1);
                if (wrap && last_row) begin
                    n_cnt   = '0;
                    n_state = tccw_pkg::S_SCR_COPY;
                end else if (r_tab == tccw_pkg::t_tab'(1)) begin
                    n_state = tccw_pkg::S_FINISH;
                end
            end

            // read row below at cnt + COLUMNS, write the word read last cycle at cnt - 1
            tccw_pkg::S_SCR_COPY: begin
                if (r_cnt != tccw_pkg::t_addr'(tccw_pkg::CELLS - tccw_pkg::COLUMNS)) begin
                    rd_en   = 1'b1;
                    rd_addr = tccw_pkg::t_addr'(int'(r_cnt) + tccw_pkg::COLUMNS);
                    n_cnt   = r_cnt + tccw_pkg::t_addr'(1);
                end else begin
                    n_state = tccw_pkg::S_SCR_FILL;
                end
                if (r_cnt != '0) begin
                    char_we = 1'b1;
                    attr_we = 1'b1;
                    wa      = r_cnt - tccw_pkg::t_addr'(1);
                    char_wd = r_rd_char;
                    attr_wd = r_rd_attr;
                end
            end

            tccw_pkg::S_SCR_FILL: begin
                char_we = 1'b1;
                attr_we = 1'b1;
                wa      = r_cnt;
                if (r_cnt == tccw_pkg::t_addr'(tccw_pkg::CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = (r_tab != '0) ? tccw_pkg::S_TAB : tccw_pkg::S_FINISH;
                end else begin
                    n_cnt = r_cnt + tccw_pkg::t_addr'(1);
                end
            end

            tccw_pkg::S_CLEAR: begin
                char_we = 1'b1;
                wa      = r_cnt;
                if (r_cnt == tccw_pkg::t_addr'(tccw_pkg::CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = tccw_pkg::S_FINISH;
                end else begin
                    n_cnt = r_cnt + tccw_pkg::t_addr'(1);
                end
            end

            tccw_pkg::S_SETALL: begin
                attr_we = 1'b1;
                wa      = r_cnt;
                attr_wd = r_color;
                if (r_cnt == tccw_pkg::t_addr'(tccw_pkg::CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = tccw_pkg::S_FINISH;
                end else begin
                    n_cnt = r_cnt + tccw_pkg::t_addr'(1);
                end
            end

            tccw_pkg::S_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = tccw_pkg::S_IDLE;
                end
            end

            default: n_state = tccw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccw_pkg::S_INIT;
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_tab   <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_row   <= n_row;
            r_tab   <= n_tab;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
    end

    // character and attribute memories, one write and one read port each
    always_ff @(posedge i_clk) begin
        if (char_we)
            r_char_mem[wa] <= char_wd;
        if (rd_en)
            r_rd_char <= r_char_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (attr_we)
            r_attr_mem[wa] <= attr_wd;
        if (rd_en)
            r_rd_attr <= r_attr_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pos   <= out_pos;
            r_out_char  <= out_char;
            r_out_color <= out_color;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.cursor_position = r_out_pos;
    assign o_out.cell_char       = r_out_char;
    assign o_out.cell_color      = r_out_color;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded over a pending beat");

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.operation == tccw_pkg::OP_READ) |-> ##2 o_out.valid)
        else $error("read result not presented two cycles after accept");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tccw_pkg::S_IDLE && !in_fire) |-> (!char_we && !attr_we))
        else $error("memory written while idle");

    a_scroll_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tccw_pkg::S_SCR_COPY && rd_en && char_we) |-> (wa < rd_addr))
        else $error("scroll copy writes ahead of its read");

endmodule
